FILE: rtl/core/wskf_pkg.sv
// ----------------------------------------------------------------------------
// Wheel speed Kalman filter package
// Shared codes, time step limits and the command type of the multiply/divide
// unit used by the filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package wskf_pkg;

   // Request commands.
   localparam logic CMD_INIT   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // Response status codes.
   localparam logic [1:0] ST_ECHO    = 2'd0;
   localparam logic [1:0] ST_UPDATED = 2'd1;
   localparam logic [1:0] ST_INIT    = 2'd2;
   localparam logic [1:0] ST_GUARD   = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_Q_SPEED   = 2'd0;
   localparam logic [1:0] CSR_Q_ACCEL   = 2'd1;
   localparam logic [1:0] CSR_MAX_ACCEL = 2'd2;

   // Time step format and limits (Q0.24 seconds, 0.0001 s to 0.1 s).
   localparam int          DT_FRAC = 24;
   localparam logic [23:0] DT_MIN  = 24'd1678;
   localparam logic [23:0] DT_MAX  = 24'd1677722;

   // Product shift selections of the multiply/divide unit.
   localparam logic [1:0] SH_24 = 2'd0;
   localparam logic [1:0] SH_25 = 2'd1;
   localparam logic [1:0] SH_26 = 2'd2;

   // Command to the multiply/divide unit.
   typedef struct packed {
      logic       divide;
      logic [1:0] shift_sel;
   } mdu_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/wskf_mdu.sv
// ----------------------------------------------------------------------------
// Wheel speed Kalman filter multiply/divide unit
// Bit-serial signed multiply with a right shift, or a multiply followed by a
// restoring division; the result saturates to 64 bits, truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wskf_mdu #(
   parameter int CW = 48
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   input  wskf_pkg::mdu_cmd_type     cmd,
   input  wire logic signed [CW:0]   a_in,
   input  wire logic signed [CW:0]   b_in,
   input  wire logic [CW-1:0]        d_in,
   output logic                      busy,
   output logic                      done,
   output logic signed [63:0]        res
);

   localparam int PW   = 2 * CW;
   localparam int CNTW = $clog2(PW);
   localparam logic [CNTW-1:0] MUL_LAST = CNTW'(CW - 1);
   localparam logic [CNTW-1:0] DIV_LAST = CNTW'(PW - 1);

   localparam logic [2:0] U_IDLE   = 3'd0;
   localparam logic [2:0] U_MUL    = 3'd1;
   localparam logic [2:0] U_MULEND = 3'd2;
   localparam logic [2:0] U_DIV    = 3'd3;
   localparam logic [2:0] U_DIVEND = 3'd4;

   logic [2:0]          phase_ff, phase_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [CW:0]         acc_ff, acc_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       amag_ff, amag_in;
   logic [CW-1:0]       dvs_ff, dvs_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [PW-1:0]       quo_ff, quo_in;
   logic                neg_ff, neg_in;
   wskf_pkg::mdu_cmd_type cmd_ff, cmd_in;
   logic signed [63:0]  res_ff, res_in;
   logic                done_ff, done_in;

   logic [CW:0]         a_neg_w, b_neg_w;
   logic [CW:0]         sum_w;
   logic [CW:0]         rem2_w;
   logic                ge_w;
   logic [PW-1:0]       prod_w;
   logic [PW-1:0]       mag_w;
   logic                big_w;
   logic signed [63:0]  sat_w;

   assign busy = (phase_ff != U_IDLE);
   assign done = done_ff;
   assign res  = res_ff;

   // Magnitudes of the operands at start.
   assign a_neg_w = -a_in;
   assign b_neg_w = -b_in;

   // Shift-add step and restoring division step.
   assign sum_w  = acc_ff + (lo_ff[0] ? {1'b0, amag_ff} : {(CW + 1){1'b0}});
   assign rem2_w = {rem_ff, quo_ff[PW-1]};
   assign ge_w   = (rem2_w >= {1'b0, dvs_ff});
   assign prod_w = {acc_ff[CW-1:0], lo_ff};

   // Magnitude to saturate: the shifted product or the quotient.
   always_comb begin
      if (phase_ff == U_DIVEND) begin
         mag_w = quo_ff;
      end else begin
         case (cmd_ff.shift_sel)
            wskf_pkg::SH_25: mag_w = prod_w >> (wskf_pkg::DT_FRAC + 1);
            wskf_pkg::SH_26: mag_w = prod_w >> (wskf_pkg::DT_FRAC + 2);
            default:         mag_w = prod_w >> wskf_pkg::DT_FRAC;
         endcase
      end
   end

   // Signed saturation to 64 bits.
   always_comb begin
      big_w = |mag_w[PW-1:63];
      if (neg_ff) begin
         sat_w = big_w ? 64'sh8000_0000_0000_0000 : -$signed(mag_w[63:0]);
      end else begin
         sat_w = big_w ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(mag_w[63:0]);
      end
   end

   // Sequencing of the multiply and divide passes.
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      lo_in    = lo_ff;
      amag_in  = amag_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      cmd_in   = cmd_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (phase_ff)
         U_IDLE: begin
            if (start) begin
               amag_in  = a_in[CW] ? a_neg_w[CW-1:0] : a_in[CW-1:0];
               lo_in    = b_in[CW] ? b_neg_w[CW-1:0] : b_in[CW-1:0];
               neg_in   = a_in[CW] ^ b_in[CW];
               acc_in   = '0;
               dvs_in   = d_in;
               cmd_in   = cmd;
               cnt_in   = '0;
               phase_in = U_MUL;
            end
         end
         U_MUL: begin
            acc_in = {1'b0, sum_w[CW:1]};
            lo_in  = {sum_w[0], lo_ff[CW-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               phase_in = U_MULEND;
            end
         end
         U_MULEND: begin
            if (cmd_ff.divide) begin
               quo_in   = prod_w;
               rem_in   = '0;
               cnt_in   = '0;
               phase_in = U_DIV;
            end else begin
               res_in   = sat_w;
               done_in  = 1'b1;
               phase_in = U_IDLE;
            end
         end
         U_DIV: begin
            rem_in = ge_w ? CW'(rem2_w - {1'b0, dvs_ff}) : rem2_w[CW-1:0];
            quo_in = {quo_ff[PW-2:0], ge_w};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               phase_in = U_DIVEND;
            end
         end
         U_DIVEND: begin
            res_in   = sat_w;
            done_in  = 1'b1;
            phase_in = U_IDLE;
         end
         default: begin
            phase_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      lo_ff   <= lo_in;
      amag_ff <= amag_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      cmd_ff  <= cmd_in;
      res_ff  <= res_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/wheel_speed_kalman_filter_core.sv
// Init and uninitialised updates answer in the cycle after the request is taken.
// A filter update runs up to 16 operations on one bit-serial multiply/divide
// unit: 10 multiplies and 6 multiply-divides, the divides skipped when the
// innovation variance is not positive; one request is in flight at a time.
// Reset (synchronous) clears the estimate and covariance, marks the filter
// uninitialised and loads q_speed = 1.0, q_accel = 1.0, max_accel = 100.0.
// ----------------------------------------------------------------------------
// Wheel speed Kalman filter core
// Two-state speed and acceleration tracker in signed fixed point, sequencing
// prediction, process noise and gain correction through one shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_speed_kalman_filter_core #(
   parameter int FRAC_BITS = 16,
   parameter int COV_WIDTH = 48
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_cmd,
   input  wire logic signed [31:0] req_speed_meas,
   input  wire logic [23:0]   req_time_step,
   input  wire logic [31:0]   req_meas_noise,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [31:0] rsp_speed_est,
   output logic signed [31:0] rsp_accel_est,
   output logic [1:0]         rsp_status,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_data
);

   localparam int CW = COV_WIDTH;
   localparam int SW = 66;
   localparam int OW = CW + 1;

   localparam logic signed [SW-1:0] CW_MAX  = (SW'(1) <<< (CW - 1)) - SW'(1);
   localparam logic signed [SW-1:0] CW_MIN  = -CW_MAX - SW'(1);
   localparam logic signed [SW-1:0] I32_MAX = SW'(64'sd2147483647);
   localparam logic signed [SW-1:0] I32_MIN = -SW'(64'sd2147483648);
   localparam longint SPD_RAW = 400 * (longint'(1) << FRAC_BITS);
   localparam logic signed [SW-1:0] SPD_MAX =
      SW'((SPD_RAW > 64'sd2147483647) ? 64'sd2147483647 : SPD_RAW);
   localparam logic signed [CW-1:0] INIT_VV = CW'(25 * (longint'(1) << FRAC_BITS));
   localparam logic signed [CW-1:0] INIT_AA = CW'(100 * (longint'(1) << FRAC_BITS));
   localparam logic [34:0] NOISE_LO = 35'(((longint'(1) << FRAC_BITS) + 50) / 100);
   localparam logic [34:0] NOISE_HI = 35'(1000) << FRAC_BITS;
   localparam logic [31:0] Q_RESET  = 32'(longint'(1) << FRAC_BITS);
   localparam logic [30:0] MA_RESET = 31'(100 * (longint'(1) << FRAC_BITS));

   // Sequencer phases.
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_START = 2'd1;
   localparam logic [1:0] PH_WAIT  = 2'd2;
   localparam logic [1:0] PH_OUT   = 2'd3;

   // Operation steps of an update.
   localparam logic [3:0] STEP_DT2  = 4'd0;
   localparam logic [3:0] STEP_DT3  = 4'd1;
   localparam logic [3:0] STEP_DT4  = 4'd2;
   localparam logic [3:0] STEP_X0   = 4'd3;
   localparam logic [3:0] STEP_P00A = 4'd4;
   localparam logic [3:0] STEP_P00B = 4'd5;
   localparam logic [3:0] STEP_DP   = 4'd6;
   localparam logic [3:0] STEP_Q00  = 4'd7;
   localparam logic [3:0] STEP_Q01  = 4'd8;
   localparam logic [3:0] STEP_Q11  = 4'd9;
   localparam logic [3:0] STEP_KX0  = 4'd10;
   localparam logic [3:0] STEP_KX1  = 4'd11;
   localparam logic [3:0] STEP_K00  = 4'd12;
   localparam logic [3:0] STEP_K01  = 4'd13;
   localparam logic [3:0] STEP_K10  = 4'd14;
   localparam logic [3:0] STEP_K11  = 4'd15;

   function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
      if (v > CW_MAX) begin
         return CW_MAX[CW-1:0];
      end
      if (v < CW_MIN) begin
         return CW_MIN[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   function automatic logic signed [SW-1:0] clamp_sw(input logic signed [SW-1:0] v,
                                                     input logic signed [SW-1:0] lo,
                                                     input logic signed [SW-1:0] hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // Configuration, filter state and working registers.
   logic [31:0]            q_speed_ff, q_speed_in;
   logic [31:0]            q_accel_ff, q_accel_in;
   logic [30:0]            max_accel_ff, max_accel_in;
   logic signed [31:0]     speed_state_ff, speed_state_in;
   logic signed [31:0]     accel_state_ff, accel_state_in;
   logic signed [CW-1:0]   cov_vv_ff, cov_vv_in;
   logic signed [CW-1:0]   cov_va_ff, cov_va_in;
   logic signed [CW-1:0]   cov_av_ff, cov_av_in;
   logic signed [CW-1:0]   cov_aa_ff, cov_aa_in;
   logic                   ready_ff, ready_in;
   logic [1:0]             phase_ff, phase_in;
   logic [3:0]             step_ff, step_in;
   logic [23:0]            dt_ff, dt_in;
   logic [23:0]            dt2_ff, dt2_in;
   logic [23:0]            dt3_ff, dt3_in;
   logic [23:0]            dt4_ff, dt4_in;
   logic [31:0]            noise_ff, noise_in;
   logic signed [31:0]     z_ff, z_in;
   logic signed [31:0]     x0_ff, x0_in;
   logic signed [32:0]     y_ff, y_in;
   logic signed [CW-1:0]   p00_ff, p00_in;
   logic signed [CW-1:0]   p01_ff, p01_in;
   logic signed [CW-1:0]   p10_ff, p10_in;
   logic signed [CW-1:0]   p11_ff, p11_in;
   logic signed [CW-1:0]   s_ff, s_in;
   logic signed [31:0]     rsp_speed_ff, rsp_speed_in;
   logic signed [31:0]     rsp_accel_ff, rsp_accel_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   // Multiply/divide unit interface.
   logic                   mdu_start;
   wskf_pkg::mdu_cmd_type  mdu_cmd;
   logic signed [OW-1:0]   mdu_a;
   logic signed [OW-1:0]   mdu_b;
   logic                   mdu_busy;
   logic                   mdu_done;
   logic signed [63:0]     mdu_res;

   logic                   req_accept;
   logic signed [SW-1:0]   res_x;
   logic signed [SW-1:0]   q01_x;
   logic signed [SW-1:0]   max_accel_x;
   logic signed [SW-1:0]   noise_x;
   logic signed [OW-1:0]   dt_op, dt2_op, dt3_op, dt4_op;
   logic [34:0]            noise_req;

   assign req_stall  = (phase_ff != PH_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (phase_ff == PH_OUT);
   assign rsp_speed_est = rsp_speed_ff;
   assign rsp_accel_est = rsp_accel_ff;
   assign rsp_status    = rsp_status_ff;
   assign csr_ready     = 1'b1;
   assign mdu_start     = (phase_ff == PH_START);

   assign res_x       = SW'(mdu_res);
   assign q01_x       = SW'(sat_cw(res_x));
   assign max_accel_x = SW'(signed'({1'b0, max_accel_ff}));
   assign noise_x     = SW'(signed'({1'b0, noise_ff}));
   assign dt_op       = OW'(signed'({1'b0, dt_ff}));
   assign dt2_op      = OW'(signed'({1'b0, dt2_ff}));
   assign dt3_op      = OW'(signed'({1'b0, dt3_ff}));
   assign dt4_op      = OW'(signed'({1'b0, dt4_ff}));
   assign noise_req   = 35'(req_meas_noise);

   // Operand selection for each step.
   always_comb begin
      mdu_cmd.divide    = 1'b0;
      mdu_cmd.shift_sel = wskf_pkg::SH_24;
      mdu_a = '0;
      mdu_b = '0;
      case (step_ff)
         STEP_DT2: begin
            mdu_a = dt_op;
            mdu_b = dt_op;
         end
         STEP_DT3: begin
            mdu_a = dt2_op;
            mdu_b = dt_op;
         end
         STEP_DT4: begin
            mdu_a = dt3_op;
            mdu_b = dt_op;
         end
         STEP_X0: begin
            mdu_a = OW'(accel_state_ff);
            mdu_b = dt_op;
         end
         STEP_P00A: begin
            mdu_a = OW'(sat_cw(SW'(cov_av_ff) + SW'(cov_va_ff)));
            mdu_b = dt_op;
         end
         STEP_P00B: begin
            mdu_a = OW'(cov_aa_ff);
            mdu_b = dt2_op;
         end
         STEP_DP: begin
            mdu_a = OW'(cov_aa_ff);
            mdu_b = dt_op;
         end
         STEP_Q00: begin
            mdu_a = OW'(signed'({1'b0, q_speed_ff}));
            mdu_b = dt4_op;
            mdu_cmd.shift_sel = wskf_pkg::SH_26;
         end
         STEP_Q01: begin
            mdu_a = OW'(signed'({1'b0, q_speed_ff}));
            mdu_b = dt3_op;
            mdu_cmd.shift_sel = wskf_pkg::SH_25;
         end
         STEP_Q11: begin
            mdu_a = OW'(signed'({1'b0, q_accel_ff}));
            mdu_b = dt2_op;
         end
         STEP_KX0: begin
            mdu_a = OW'(p00_ff);
            mdu_b = OW'(y_ff);
            mdu_cmd.divide = 1'b1;
         end
         STEP_KX1: begin
            mdu_a = OW'(p10_ff);
            mdu_b = OW'(y_ff);
            mdu_cmd.divide = 1'b1;
         end
         STEP_K00: begin
            mdu_a = OW'(p00_ff);
            mdu_b = OW'(p00_ff);
            mdu_cmd.divide = 1'b1;
         end
         STEP_K01: begin
            mdu_a = OW'(p00_ff);
            mdu_b = OW'(p01_ff);
            mdu_cmd.divide = 1'b1;
         end
         STEP_K10: begin
            mdu_a = OW'(p10_ff);
            mdu_b = OW'(p00_ff);
            mdu_cmd.divide = 1'b1;
         end
         STEP_K11: begin
            mdu_a = OW'(p10_ff);
            mdu_b = OW'(p01_ff);
            mdu_cmd.divide = 1'b1;
         end
         default: begin
            mdu_a = '0;
            mdu_b = '0;
         end
      endcase
   end

   // Request handling, step results and configuration writes.
   always_comb begin
      q_speed_in     = q_speed_ff;
      q_accel_in     = q_accel_ff;
      max_accel_in   = max_accel_ff;
      speed_state_in = speed_state_ff;
      accel_state_in = accel_state_ff;
      cov_vv_in      = cov_vv_ff;
      cov_va_in      = cov_va_ff;
      cov_av_in      = cov_av_ff;
      cov_aa_in      = cov_aa_ff;
      ready_in       = ready_ff;
      phase_in       = phase_ff;
      step_in        = step_ff;
      dt_in          = dt_ff;
      dt2_in         = dt2_ff;
      dt3_in         = dt3_ff;
      dt4_in         = dt4_ff;
      noise_in       = noise_ff;
      z_in           = z_ff;
      x0_in          = x0_ff;
      y_in           = y_ff;
      p00_in         = p00_ff;
      p01_in         = p01_ff;
      p10_in         = p10_ff;
      p11_in         = p11_ff;
      s_in           = s_ff;
      rsp_speed_in   = rsp_speed_ff;
      rsp_accel_in   = rsp_accel_ff;
      rsp_status_in  = rsp_status_ff;

      if (csr_valid) begin
         case (csr_index)
            wskf_pkg::CSR_Q_SPEED:   q_speed_in   = csr_data;
            wskf_pkg::CSR_Q_ACCEL:   q_accel_in   = csr_data;
            wskf_pkg::CSR_MAX_ACCEL: max_accel_in = csr_data[30:0];
            default: begin
               q_speed_in = q_speed_ff;
            end
         endcase
      end

      case (phase_ff)
         PH_IDLE: begin
            if (req_accept) begin
               if (req_cmd == wskf_pkg::CMD_INIT) begin
                  speed_state_in = req_speed_meas;
                  accel_state_in = '0;
                  cov_vv_in      = INIT_VV;
                  cov_va_in      = '0;
                  cov_av_in      = '0;
                  cov_aa_in      = INIT_AA;
                  ready_in       = 1'b1;
                  rsp_speed_in   = req_speed_meas;
                  rsp_accel_in   = '0;
                  rsp_status_in  = wskf_pkg::ST_INIT;
                  phase_in       = PH_OUT;
               end else if (!ready_ff) begin
                  rsp_speed_in  = req_speed_meas;
                  rsp_accel_in  = accel_state_ff;
                  rsp_status_in = wskf_pkg::ST_ECHO;
                  phase_in      = PH_OUT;
               end else begin
                  // Clamp the time step and the measurement noise.
                  if (req_time_step < wskf_pkg::DT_MIN) begin
                     dt_in = wskf_pkg::DT_MIN;
                  end else if (req_time_step > wskf_pkg::DT_MAX) begin
                     dt_in = wskf_pkg::DT_MAX;
                  end else begin
                     dt_in = req_time_step;
                  end
                  if (noise_req < NOISE_LO) begin
                     noise_in = NOISE_LO[31:0];
                  end else if (noise_req > NOISE_HI) begin
                     noise_in = NOISE_HI[31:0];
                  end else begin
                     noise_in = req_meas_noise;
                  end
                  z_in     = req_speed_meas;
                  step_in  = STEP_DT2;
                  phase_in = PH_START;
               end
            end
         end
         PH_START: begin
            phase_in = PH_WAIT;
         end
         PH_WAIT: begin
            if (mdu_done) begin
               step_in  = step_ff + 4'd1;
               phase_in = PH_START;
               case (step_ff)
                  STEP_DT2: dt2_in = mdu_res[23:0];
                  STEP_DT3: dt3_in = mdu_res[23:0];
                  STEP_DT4: dt4_in = mdu_res[23:0];
                  STEP_X0: begin
                     x0_in = 32'(clamp_sw(SW'(speed_state_ff) + res_x, I32_MIN, I32_MAX));
                  end
                  STEP_P00A: p00_in = sat_cw(SW'(cov_vv_ff) + res_x);
                  STEP_P00B: p00_in = sat_cw(SW'(p00_ff) + res_x);
                  STEP_DP: begin
                     p01_in = sat_cw(SW'(cov_va_ff) + res_x);
                     p10_in = sat_cw(SW'(cov_av_ff) + res_x);
                     p11_in = cov_aa_ff;
                  end
                  STEP_Q00: p00_in = sat_cw(SW'(p00_ff) + q01_x);
                  STEP_Q01: begin
                     p01_in = sat_cw(SW'(p01_ff) + q01_x);
                     p10_in = sat_cw(SW'(p10_ff) + q01_x);
                  end
                  STEP_Q11: begin
                     // Innovation and its variance; a non-positive variance
                     // returns the prediction and leaves the state alone.
                     p11_in = sat_cw(SW'(p11_ff) + q01_x);
                     y_in   = 33'(z_ff) - 33'(x0_ff);
                     s_in   = sat_cw(SW'(p00_ff) + noise_x);
                     if (s_in[CW-1] || (s_in == '0)) begin
                        rsp_speed_in  = x0_ff;
                        rsp_accel_in  = accel_state_ff;
                        rsp_status_in = wskf_pkg::ST_GUARD;
                        phase_in      = PH_OUT;
                     end
                  end
                  STEP_KX0: begin
                     speed_state_in = 32'(clamp_sw(SW'(x0_ff) + res_x, SW'(0), SPD_MAX));
                  end
                  STEP_KX1: begin
                     accel_state_in = 32'(clamp_sw(SW'(accel_state_ff) + res_x,
                                                   -max_accel_x, max_accel_x));
                  end
                  STEP_K00: cov_vv_in = sat_cw(SW'(p00_ff) - res_x);
                  STEP_K01: cov_va_in = sat_cw(SW'(p01_ff) - res_x);
                  STEP_K10: cov_av_in = sat_cw(SW'(p10_ff) - res_x);
                  STEP_K11: begin
                     cov_aa_in     = sat_cw(SW'(p11_ff) - res_x);
                     rsp_speed_in  = speed_state_ff;
                     rsp_accel_in  = accel_state_ff;
                     rsp_status_in = wskf_pkg::ST_UPDATED;
                     phase_in      = PH_OUT;
                  end
                  default: begin
                     phase_in = PH_OUT;
                  end
               endcase
            end
         end
         PH_OUT: begin
            if (!rsp_stall) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_speed_ff     <= Q_RESET;
         q_accel_ff     <= Q_RESET;
         max_accel_ff   <= MA_RESET;
         speed_state_ff <= '0;
         accel_state_ff <= '0;
         cov_vv_ff      <= '0;
         cov_va_ff      <= '0;
         cov_av_ff      <= '0;
         cov_aa_ff      <= '0;
         ready_ff       <= 1'b0;
         phase_ff       <= PH_IDLE;
         step_ff        <= STEP_DT2;
      end else begin
         q_speed_ff     <= q_speed_in;
         q_accel_ff     <= q_accel_in;
         max_accel_ff   <= max_accel_in;
         speed_state_ff <= speed_state_in;
         accel_state_ff <= accel_state_in;
         cov_vv_ff      <= cov_vv_in;
         cov_va_ff      <= cov_va_in;
         cov_av_ff      <= cov_av_in;
         cov_aa_ff      <= cov_aa_in;
         ready_ff       <= ready_in;
         phase_ff       <= phase_in;
         step_ff        <= step_in;
      end
      dt_ff         <= dt_in;
      dt2_ff        <= dt2_in;
      dt3_ff        <= dt3_in;
      dt4_ff        <= dt4_in;
      noise_ff      <= noise_in;
      z_ff          <= z_in;
      x0_ff         <= x0_in;
      y_ff          <= y_in;
      p00_ff        <= p00_in;
      p01_ff        <= p01_in;
      p10_ff        <= p10_in;
      p11_ff        <= p11_in;
      s_ff          <= s_in;
      rsp_speed_ff  <= rsp_speed_in;
      rsp_accel_ff  <= rsp_accel_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Shared multiply/divide unit.
   wskf_mdu #(
      .CW(CW)
   ) u_mdu (
      .clock (clock),
      .reset (reset),
      .start (mdu_start),
      .cmd   (mdu_cmd),
      .a_in  (mdu_a),
      .b_in  (mdu_b),
      .d_in  (s_ff),
      .busy  (mdu_busy),
      .done  (mdu_done),
      .res   (mdu_res)
   );

`ifndef SYNTH
   // The unit is only started when it has finished its previous operation.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mdu_start |-> !mdu_busy)
      else $error("multiply/divide unit started while busy");

   // An updated speed estimate is never negative.
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == wskf_pkg::ST_UPDATED)) |-> !rsp_speed_est[31])
      else $error("updated speed estimate out of range");

   // An init request answers in the next cycle with zero acceleration.
   a_init_resp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_cmd == wskf_pkg::CMD_INIT)) |=>
      (rsp_valid && (rsp_status == wskf_pkg::ST_INIT) && (rsp_accel_est == '0)))
      else $error("init request not answered");

   // Before init, an update request is echoed at once.
   a_echo_resp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_cmd == wskf_pkg::CMD_UPDATE) && !ready_ff) |=>
      (rsp_valid && (rsp_status == wskf_pkg::ST_ECHO)))
      else $error("uninitialised update not echoed");
`endif

endmodule

`default_nettype wire
